FILE: design/tpm_pkg.sv
// Shared constants, types and helper functions for the text pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

	// Geometry
	localparam int PATTERN_MAX = 256;
	localparam int SYM_W       = 21;
	localparam int IDX_W       = 32;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 2;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
	localparam logic [OP_W-1:0] OP_END    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMART_CASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_WORD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_BYTES  = 2'd3;

	// Per-request control broadcast to every cell
	typedef struct packed {
		logic             shift;     // append: pattern shifts one cell down
		logic             clear_all; // empty the pattern
		logic             zero_bits; // drop all partial matches
		logic             step;      // text element: update partial matches
		logic             kill_old;  // pending match confirmed: old bits count as zero
		logic             inject;    // a match may start at this element
		logic             fold;      // compare case-insensitively
		logic [SYM_W-1:0] key;       // text symbol, folded when fold is set
		logic             flush;     // match completed: clear all new bits
	} cell_ctl_t;

	// One result
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_start;
		logic [IDX_W-1:0] match_end;
		logic             overflow;
	} result_t;

	function automatic logic is_lower(input logic [SYM_W-1:0] c);
		return (c >= SYM_W'(8'h61)) && (c <= SYM_W'(8'h7A));
	endfunction

	function automatic logic is_upper(input logic [SYM_W-1:0] c);
		return (c >= SYM_W'(8'h41)) && (c <= SYM_W'(8'h5A));
	endfunction

	function automatic logic is_word(input logic [SYM_W-1:0] c);
		return is_lower(c) || is_upper(c) ||
			((c >= SYM_W'(8'h30)) && (c <= SYM_W'(8'h39))) || (c == SYM_W'(8'h5F));
	endfunction

	function automatic logic [SYM_W-1:0] to_upper(input logic [SYM_W-1:0] c);
		return is_lower(c) ? (c - SYM_W'(8'h20)) : c;
	endfunction

endpackage
`default_nettype wire

FILE: design/tpm_cell.sv
// One matcher cell: a pattern symbol, its occupied flag and its partial-match bit.
`timescale 1ns / 1ps
`default_nettype none
module tpm_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tpm_pkg::cell_ctl_t       ctl,
	// from the lower neighbor (earlier pattern position)
	input  wire logic                     prev_active,
	input  wire logic                     prev_bit,
	// from the upper neighbor (pattern shifts down on append)
	input  wire logic [tpm_pkg::SYM_W-1:0] next_sym,
	input  wire logic                     next_active,
	output logic [tpm_pkg::SYM_W-1:0]     sym_q,
	output logic                          active_q,
	output logic                          bit_q,
	output logic                          bit_next
);

	logic                      hit_in;
	logic [tpm_pkg::SYM_W-1:0] pat;
	logic                      eq;

	// Predecessor bit: first occupied cell takes the start flag instead
	always_comb begin
		if (prev_active) begin
			hit_in = prev_bit && !ctl.kill_old;
		end else begin
			hit_in = ctl.inject;
		end
		pat      = ctl.fold ? tpm_pkg::to_upper(sym_q) : sym_q;
		eq       = (pat == ctl.key);
		bit_next = active_q && eq && hit_in;
	end

	// Occupied flag and partial-match bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bit_q    <= 1'b0;
		end else begin
			if (ctl.clear_all) begin
				active_q <= 1'b0;
			end else if (ctl.shift) begin
				active_q <= next_active;
			end
			if (ctl.zero_bits) begin
				bit_q <= 1'b0;
			end else if (ctl.step) begin
				bit_q <= bit_next && !ctl.flush;
			end
		end
	end

	// Pattern symbol
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sym_q <= next_sym;
		end
	end

endmodule
`default_nettype wire

FILE: design/tpm_out_reg.sv
// Result output register with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
module tpm_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire tpm_pkg::result_t res_in,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output tpm_pkg::result_t      res_q,
	output logic                  can_load
);

	// Room when empty or when the held result leaves this cycle
	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
`default_nettype wire

FILE: design/text_pattern_matcher_unit.sv
// Top level of the streaming exact string matcher.
//
// Usage: the request channel (in_valid/in_ready, opcode, symbol) carries
// pattern clears, pattern appends, text elements and end-of-text marks. Every
// accepted request gives exactly one result on the result channel
// (out_valid/out_ready, found, match_start, match_end, overflow).
// The result is registered: it is valid on the edge after acceptance.
// Throughput is one request per cycle unless stalled; all pattern positions
// are compared in parallel by a row of PATTERN_MAX cells, each updating its
// partial-match bit from its lower neighbor's bit in the same cycle.
// The pattern is held right-aligned: an append shifts the row down one cell,
// so the last pattern element always sits in the top cell.
// A stalled receiver holds the result register; in_ready is low only while
// a result waits and out_ready is low.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them only while no request is in flight; nothing here enforces it.
// Reset clears the pattern and the text state, empties the result register and
// sets smart case on; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module text_pattern_matcher_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tpm_pkg::OP_W-1:0]       opcode,
	input  wire logic [tpm_pkg::SYM_W-1:0]      symbol,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                found,
	output logic [tpm_pkg::IDX_W-1:0]           match_start,
	output logic [tpm_pkg::IDX_W-1:0]           match_end,
	output logic                                overflow,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [tpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic                           cfg_data
);

	localparam int N = tpm_pkg::PATTERN_MAX;

	// Configuration registers
	logic cfg_fold_q, cfg_smart_q, cfg_word_q, cfg_raw_q;
	// Pattern and text state
	logic [tpm_pkg::LEN_W-1:0] len_q;
	logic                      lower_seen_q, upper_seen_q;
	logic                      prev_word_q;
	logic                      pend_valid_q;
	logic [tpm_pkg::IDX_W-1:0] pend_start_q;
	logic [tpm_pkg::IDX_W-1:0] elem_idx_q;

	logic                       in_fire;
	logic                       word_mode, fold, cur_word, full, last_hit, pend_hit;
	logic [tpm_pkg::IDX_W-1:0]  start_s, idx_inc;
	tpm_pkg::cell_ctl_t         ctl;
	tpm_pkg::result_t           res, res_q;

	logic [N-1:0]               act_vec, bit_vec, nxt_vec;
	logic [tpm_pkg::SYM_W-1:0]  sym_a [N];

	assign in_fire = in_valid && in_ready;

	// Effective modes
	always_comb begin
		word_mode = !cfg_raw_q && cfg_word_q;
		fold      = !cfg_raw_q && (cfg_fold_q || (cfg_smart_q && lower_seen_q && !upper_seen_q));
		cur_word  = tpm_pkg::is_word(symbol);
		full      = (len_q == tpm_pkg::LEN_W'(N));
		last_hit  = nxt_vec[N-1];
		pend_hit  = pend_valid_q && word_mode && !cur_word;
		idx_inc   = elem_idx_q + tpm_pkg::IDX_W'(1);
		start_s   = idx_inc - {{(tpm_pkg::IDX_W - tpm_pkg::LEN_W){1'b0}}, len_q};
	end

	// Cell control and result for the request at the port
	always_comb begin
		ctl           = '0;
		ctl.fold      = fold;
		ctl.key       = fold ? tpm_pkg::to_upper(symbol) : symbol;
		ctl.inject    = word_mode ? !prev_word_q : 1'b1;
		ctl.kill_old  = pend_hit;
		ctl.flush     = !word_mode && last_hit;
		res           = '0;
		case (opcode)
			tpm_pkg::OP_CLEAR: begin
				ctl.clear_all = in_fire;
				ctl.zero_bits = in_fire;
			end
			tpm_pkg::OP_APPEND: begin
				ctl.shift     = in_fire && !full;
				ctl.zero_bits = in_fire;
				res.overflow  = full;
			end
			tpm_pkg::OP_TEXT: begin
				ctl.step = in_fire;
				if (pend_hit) begin
					res.found       = 1'b1;
					res.match_start = pend_start_q;
					res.match_end   = elem_idx_q;
				end else if (!word_mode && last_hit) begin
					res.found       = 1'b1;
					res.match_start = start_s;
					res.match_end   = idx_inc;
				end
			end
			tpm_pkg::OP_END: begin
				ctl.zero_bits = in_fire;
				if (pend_valid_q) begin
					res.found       = 1'b1;
					res.match_start = pend_start_q;
					res.match_end   = elem_idx_q;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Row of matcher cells
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic                      p_act, p_bit, n_act;
			logic [tpm_pkg::SYM_W-1:0] n_sym;
			if (g == 0) begin : g_lo
				assign p_act = 1'b0;
				assign p_bit = 1'b0;
			end else begin : g_lo
				assign p_act = act_vec[g-1];
				assign p_bit = bit_vec[g-1];
			end
			if (g == N - 1) begin : g_hi
				assign n_act = 1'b1;
				assign n_sym = symbol;
			end else begin : g_hi
				assign n_act = act_vec[g+1];
				assign n_sym = sym_a[g+1];
			end
			tpm_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.prev_active (p_act),
				.prev_bit    (p_bit),
				.next_sym    (n_sym),
				.next_active (n_act),
				.sym_q       (sym_a[g]),
				.active_q    (act_vec[g]),
				.bit_q       (bit_vec[g]),
				.bit_next    (nxt_vec[g])
			);
		end
	endgenerate

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_fold_q  <= 1'b0;
			cfg_smart_q <= 1'b1;
			cfg_word_q  <= 1'b0;
			cfg_raw_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpm_pkg::REG_FOLD_CASE:  cfg_fold_q  <= cfg_data;
				tpm_pkg::REG_SMART_CASE: cfg_smart_q <= cfg_data;
				tpm_pkg::REG_WHOLE_WORD: cfg_word_q  <= cfg_data;
				tpm_pkg::REG_RAW_BYTES:  cfg_raw_q   <= cfg_data;
				default:                 cfg_raw_q   <= cfg_raw_q;
			endcase
		end
	end

	// Pattern length, case history and text position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			lower_seen_q <= 1'b0;
			upper_seen_q <= 1'b0;
			prev_word_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_start_q <= '0;
			elem_idx_q   <= '0;
		end else if (in_fire) begin
			case (opcode)
				tpm_pkg::OP_CLEAR: begin
					len_q        <= '0;
					lower_seen_q <= 1'b0;
					upper_seen_q <= 1'b0;
					prev_word_q  <= 1'b0;
					pend_valid_q <= 1'b0;
					pend_start_q <= '0;
					elem_idx_q   <= '0;
				end
				tpm_pkg::OP_APPEND: begin
					if (!full) begin
						len_q <= len_q + tpm_pkg::LEN_W'(1);
						if (tpm_pkg::is_lower(symbol)) lower_seen_q <= 1'b1;
						if (tpm_pkg::is_upper(symbol)) upper_seen_q <= 1'b1;
					end
					pend_valid_q <= 1'b0;
				end
				tpm_pkg::OP_TEXT: begin
					pend_valid_q <= word_mode && last_hit;
					if (word_mode && last_hit) begin
						pend_start_q <= start_s;
					end
					prev_word_q <= cur_word;
					elem_idx_q  <= idx_inc;
				end
				tpm_pkg::OP_END: begin
					prev_word_q  <= 1'b0;
					pend_valid_q <= 1'b0;
					pend_start_q <= '0;
					elem_idx_q   <= '0;
				end
				default: begin
					elem_idx_q <= elem_idx_q;
				end
			endcase
		end
	end

	// Result register
	tpm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.res_in    (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q),
		.can_load  (in_ready)
	);

	assign found       = res_q.found;
	assign match_start = res_q.match_start;
	assign match_end   = res_q.match_end;
	assign overflow    = res_q.overflow;

`ifndef SYNTHESIS
	// Top cell is occupied exactly when the pattern is not empty
	a_top_cell: assert property (@(posedge clk) disable iff (!arst_n)
		act_vec[N-1] == (len_q != '0))
		else $error("top cell occupancy disagrees with pattern length");

	// A pending candidate needs a pattern
	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (len_q != '0))
		else $error("pending match with empty pattern");

	// Clear empties the pattern on the next edge
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && opcode == tpm_pkg::OP_CLEAR) |=> (len_q == '0 && act_vec == '0))
		else $error("clear did not empty the pattern");

	// A match always spans at least one element
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (match_end != match_start))
		else $error("empty match reported");

	// Overflow and a match never come together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && overflow))
		else $error("overflow and match in one result");
`endif

endmodule
`default_nettype wire
